### rtl/bcld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcld_pkg
// Shared types and register codes of the button click / long-click detector.
// ----------------------------------------------------------------------------
package bcld_pkg;

  localparam int CfgWidth   = 16;
  localparam int CfgIdxW    = 2;
  localparam int IdxWidth   = 3;
  localparam int MaskWidth  = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PUSH_QUALIFY = 2'd0,
    REG_CLICK_MIN    = 2'd1,
    REG_LONG_CLICK   = 2'd2,
    REG_ENABLE_MASK  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [IdxWidth-1:0] button_index;
    logic                pin_level;
  } in_word_t;

  typedef struct packed {
    logic [IdxWidth-1:0] event_button;
    logic                click_event;
    logic                long_click_event;
  } out_word_t;

  typedef struct packed {
    logic long_pend;
    logic click_pend;
    logic acted;
    logic held;
  } flags_t;

  typedef struct packed {
    logic [CfgWidth-1:0]  push_qualify_ticks;
    logic [CfgWidth-1:0]  click_min_ticks;
    logic [CfgWidth-1:0]  long_click_ticks;
    logic [MaskWidth-1:0] button_enable_mask;
  } cfg_t;

endpackage

### rtl/button_click_longclick_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_longclick_detector
// Debounced click and long-click detection for up to NUM_BUTTONS buttons,
// per-button state in a synchronous memory with read-modify-write.
// ----------------------------------------------------------------------------
// Pipeline: s1 and output registers; 1 word per cycle unless out_stall holds.
// State is read on accept and written back as the word leaves s1, with a
//   bypass when consecutive words hit the same button.
// Reset: synchronous rst_n clears control state, config to defaults and all
//   per-entry valid bits, so every button entry reads as zero.
module button_click_longclick_detector #(
  parameter int NUM_BUTTONS = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bcld_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bcld_pkg::out_word_t             out_word,
  input  logic                            cfg_we,
  input  logic [bcld_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bcld_pkg::CfgWidth-1:0]   cfg_data
);
  import bcld_pkg::*;

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int EW = 4 + 2 * COUNT_WIDTH;

  cfg_t                   cfg_r;
  logic [EW-1:0]          mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] ent_vld_r;
  logic [EW-1:0]          rd_data_r;
  logic                   rd_vld_r;
  logic                   fwd_r;
  logic [EW-1:0]          fwd_data_r;

  logic                   s1_valid_r;
  in_word_t               s1_word_r;
  logic                   out_valid_r;
  out_word_t              out_word_r;

  logic                   advance;
  logic                   accept;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic                   wr_en;
  logic [EW-1:0]          wr_data;
  logic [EW-1:0]          entry;
  logic                   s1_en;

  flags_t                 fl_new;
  logic [COUNT_WIDTH-1:0] pc_new;
  logic [COUNT_WIDTH-1:0] hc_new;
  logic                   click_ev;
  logic                   long_ev;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign rd_addr  = AW'(in_word.button_index);
  assign wr_addr  = AW'(s1_word_r.button_index);

  assign s1_en = (32'(s1_word_r.button_index) < 32'(NUM_BUTTONS)) &&
                 cfg_r.button_enable_mask[s1_word_r.button_index];

  always_comb begin
    if (fwd_r) begin
      entry = fwd_data_r;
    end else if (rd_vld_r) begin
      entry = rd_data_r;
    end else begin
      entry = '0;
    end
  end

  bcld_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cfg       (cfg_r),
    .pressed   (!s1_word_r.pin_level),
    .flags_in  (flags_t'(entry[EW-1 -: 4])),
    .press_in  (entry[COUNT_WIDTH-1:0]),
    .hold_in   (entry[2*COUNT_WIDTH-1:COUNT_WIDTH]),
    .flags_out (fl_new),
    .press_out (pc_new),
    .hold_out  (hc_new),
    .click_ev  (click_ev),
    .long_ev   (long_ev)
  );

  assign wr_en   = s1_valid_r && s1_en && advance;
  assign wr_data = {fl_new, hc_new, pc_new};

  // state memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data_r  <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_r[wr_addr] <= 1'b1;
      end
      if (accept) begin
        rd_vld_r <= ent_vld_r[rd_addr];
        // bypass the write-back landing on the entry being read
        fwd_r    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.push_qualify_ticks <= CfgWidth'(3);
      cfg_r.click_min_ticks    <= CfgWidth'(2);
      cfg_r.long_click_ticks   <= CfgWidth'(100);
      cfg_r.button_enable_mask <= {MaskWidth{1'b1}};
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PUSH_QUALIFY: cfg_r.push_qualify_ticks <= cfg_data;
        REG_CLICK_MIN:    cfg_r.click_min_ticks    <= cfg_data;
        REG_LONG_CLICK:   cfg_r.long_click_ticks   <= cfg_data;
        REG_ENABLE_MASK:  cfg_r.button_enable_mask <= cfg_data[MaskWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_word;
    end
    if (advance && s1_valid_r) begin
      out_word_r.event_button     <= s1_word_r.button_index;
      out_word_r.click_event      <= s1_en && click_ev;
      out_word_r.long_click_event <= s1_en && long_ev;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with no word in flight");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(accept) && $past(wr_en) && ($past(wr_addr) == $past(rd_addr))) |-> fwd_r)
    else $error("same-entry write-back not bypassed");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.click_event && out_word_r.long_click_event))
    else $error("click and long click reported together");

  a_write_enabled_only: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_valid_r && s1_en))
    else $error("state written for a skipped button");
`endif

endmodule

### rtl/bcld_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcld_step
// Per-tick update of one button entry: debounce, hold count and event flags.
// ----------------------------------------------------------------------------
module bcld_step #(
  parameter int COUNT_WIDTH = 16
) (
  input  bcld_pkg::cfg_t           cfg,
  input  logic                     pressed,
  input  bcld_pkg::flags_t         flags_in,
  input  logic [COUNT_WIDTH-1:0]   press_in,
  input  logic [COUNT_WIDTH-1:0]   hold_in,
  output bcld_pkg::flags_t         flags_out,
  output logic [COUNT_WIDTH-1:0]   press_out,
  output logic [COUNT_WIDTH-1:0]   hold_out,
  output logic                     click_ev,
  output logic                     long_ev
);
  import bcld_pkg::*;

  localparam int CmpW = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

  flags_t                 fl;
  logic [COUNT_WIDTH-1:0] pc;
  logic [COUNT_WIDTH-1:0] hc;
  logic                   released;

  always_comb begin
    fl       = flags_in;
    released = 1'b0;
    click_ev = 1'b0;
    long_ev  = 1'b0;
    pc = pressed ? ((press_in == CountMax) ? CountMax : press_in + CountOne) : '0;
    hc = hold_in;
    if (CmpW'(pc) >= CmpW'(cfg.push_qualify_ticks)) begin
      fl.held = 1'b1;
    end
    if (fl.held) begin
      if (pc != '0) begin
        hc = (hc == CountMax) ? CountMax : hc + CountOne;
      end else begin
        fl.held  = 1'b0;
        released = 1'b1;
      end
      if (!fl.acted && (CmpW'(hc) >= CmpW'(cfg.long_click_ticks))) begin
        fl.held      = 1'b0;
        fl.long_pend = 1'b1;
        fl.acted     = 1'b1;
      end
    end
    if (released) begin
      if (!fl.acted && (CmpW'(hc) >= CmpW'(cfg.click_min_ticks))) begin
        fl.click_pend = 1'b1;
      end
      hc       = '0;
      fl.acted = 1'b0;
    end
    // report only an event that stands alone
    if (!fl.held && fl.click_pend && !fl.long_pend) begin
      click_ev      = 1'b1;
      fl.click_pend = 1'b0;
    end else if (!fl.held && !fl.click_pend && fl.long_pend) begin
      long_ev      = 1'b1;
      fl.long_pend = 1'b0;
    end
    flags_out = fl;
    press_out = pc;
    hold_out  = hc;
  end

endmodule

### bench/tb_button_click_longclick_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_click_longclick_detector
// Drives poll ticks into the click / long-click detector under random
// idling on both channels. A per-button copy of the debounce and hold logic
// predicts every event word, and each word that comes out is checked in order.
// The run covers several register settings, a press held below huge
// thresholds and a long receiver hold-off.
// ----------------------------------------------------------------------------

class click_tracker;

  localparam int NumButtons = 8;
  localparam logic [15:0] CountMax = 16'hFFFF;

  logic [15:0]       qualify_ticks;
  logic [15:0]       click_min;
  logic [15:0]       long_ticks;
  logic [7:0]        enable_mask;
  logic [15:0]       press_cnt [NumButtons];
  logic [15:0]       hold_cnt [NumButtons];
  bcld_pkg::flags_t  flags [NumButtons];
  bcld_pkg::out_word_t due_events [$];
  int unsigned       faults;

  function new();
    qualify_ticks = 16'd3;
    click_min     = 16'd2;
    long_ticks    = 16'd100;
    enable_mask   = 8'hFF;
    faults        = 0;
    for (int b = 0; b < NumButtons; b++) begin
      press_cnt[b] = '0;
      hold_cnt[b]  = '0;
      flags[b]     = '0;
    end
  endfunction

  function void set_reg(bcld_pkg::cfg_reg_t r, logic [15:0] v);
    case (r)
      bcld_pkg::REG_PUSH_QUALIFY: qualify_ticks = v;
      bcld_pkg::REG_CLICK_MIN:    click_min = v;
      bcld_pkg::REG_LONG_CLICK:   long_ticks = v;
      bcld_pkg::REG_ENABLE_MASK:  enable_mask = v[7:0];
      default: ;
    endcase
  endfunction

  function logic [15:0] bump(logic [15:0] v);
    return (v == CountMax) ? v : v + 16'd1;
  endfunction

  // One poll tick of one button: update its entry and return the event word.
  function bcld_pkg::out_word_t advance_button(bcld_pkg::in_word_t w);
    bcld_pkg::out_word_t ev;
    bcld_pkg::flags_t    fl;
    logic [15:0]         pc;
    logic [15:0]         hc;
    int unsigned         idx;
    bit                  released;
    idx = w.button_index;
    ev.event_button     = w.button_index;
    ev.click_event      = 1'b0;
    ev.long_click_event = 1'b0;
    if (!enable_mask[idx]) return ev;
    fl = flags[idx];
    pc = press_cnt[idx];
    hc = hold_cnt[idx];
    released = 1'b0;
    pc = (w.pin_level == 1'b0) ? bump(pc) : '0;
    if (pc >= qualify_ticks) fl.held = 1'b1;
    if (fl.held) begin
      if (pc != '0) begin
        hc = bump(hc);
      end else begin
        fl.held = 1'b0;
        released = 1'b1;
      end
      if (!fl.acted && hc >= long_ticks) begin
        fl.held      = 1'b0;
        fl.long_pend = 1'b1;
        fl.acted     = 1'b1;
      end
    end
    if (released) begin
      if (!fl.acted && hc >= click_min) fl.click_pend = 1'b1;
      hc = '0;
      fl.acted = 1'b0;
    end
    // report only when the pending flag stands alone
    if (fl.click_pend && !fl.held && !fl.long_pend) begin
      ev.click_event = 1'b1;
      fl.click_pend = 1'b0;
    end else if (fl.long_pend && !fl.held && !fl.click_pend) begin
      ev.long_click_event = 1'b1;
      fl.long_pend = 1'b0;
    end
    flags[idx]     = fl;
    press_cnt[idx] = pc;
    hold_cnt[idx]  = hc;
    return ev;
  endfunction

  function void note_tick(bcld_pkg::in_word_t w);
    due_events.push_back(advance_button(w));
  endfunction

  function void check_event(bcld_pkg::out_word_t got);
    bcld_pkg::out_word_t want;
    if (due_events.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("unexpected event word: button %0d click %0b long %0b",
                 got.event_button, got.click_event, got.long_click_event);
      return;
    end
    want = due_events.pop_front();
    if (got.event_button !== want.event_button || got.click_event !== want.click_event ||
        got.long_click_event !== want.long_click_event) begin
      faults++;
      if (faults <= 10)
        $display("event mismatch: expected button %0d click %0b long %0b, got %0d %0b %0b",
                 want.event_button, want.click_event, want.long_click_event,
                 got.event_button, got.click_event, got.long_click_event);
    end
  endfunction

  function int unsigned outstanding();
    return due_events.size();
  endfunction

endclass

module tb_button_click_longclick_detector;

  import bcld_pkg::*;

  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned HoldOffCycles = 300;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_word;
  logic       cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgWidth-1:0] cfg_data;

  click_tracker tracker = new();
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;

  button_click_longclick_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_tick(input in_word_t w);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    tracker.note_tick(w);
  endtask

  task automatic send_run(input int unsigned button, input bit level, input int unsigned count);
    in_word_t w;
    w.button_index = 3'(button);
    w.pin_level    = level;
    repeat (count) send_tick(w);
  endtask

  // Drop valid and hold until every event word is back.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] q, input logic [15:0] c,
                                input logic [15:0] l, input logic [7:0] m);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_PUSH_QUALIFY;
    cfg_data  <= q;
    tracker.set_reg(REG_PUSH_QUALIFY, q);
    @(posedge clk);
    cfg_index <= REG_CLICK_MIN;
    cfg_data  <= c;
    tracker.set_reg(REG_CLICK_MIN, c);
    @(posedge clk);
    cfg_index <= REG_LONG_CLICK;
    cfg_data  <= l;
    tracker.set_reg(REG_LONG_CLICK, l);
    @(posedge clk);
    cfg_index <= REG_ENABLE_MASK;
    cfg_data  <= {8'h00, m};
    tracker.set_reg(REG_ENABLE_MASK, {8'h00, m});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] q, input logic [15:0] c, input logic [15:0] l,
                           input logic [7:0] m, input int unsigned quota, input bit squeeze);
    int unsigned counted, tries, span, dur, b;
    bit          level [8];
    int unsigned left [8];
    in_word_t    w;
    apply_settings(q, c, l, m);
    for (int i = 0; i < 8; i++) begin
      level[i] = 1'b1;
      left[i]  = 0;
    end
    counted = 0;
    tries   = 0;
    span    = 7;
    while (counted < quota && tries < 3 * quota) begin
      if (tries % 64 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
        span    = $urandom_range(0, 7);
      end
      // long receiver hold-off with the sender pushing flat out
      if (squeeze && tries == 40) hold_request = 1'b1;
      if (squeeze && tries >= 40 && tries < 100) no_idle = 1'b1;
      if (tries == quota / 2) settle();
      w.button_index = 3'($urandom_range(0, span));
      if ($urandom_range(0, 11) == 0) begin
        w.pin_level = 1'($urandom_range(0, 1));
      end else begin
        b = w.button_index;
        if (left[b] == 0) begin
          level[b] = !level[b];
          if (level[b]) begin
            dur = $urandom_range(1, 6);
          end else begin
            case ($urandom_range(0, 3))
              0: dur = $urandom_range(1, 4);
              1: dur = q + c + $urandom_range(0, 2);
              2: begin
                dur = q + l + $urandom_range(0, 4);
                if (dur > 2) dur -= 2;
              end
              default: dur = $urandom_range(1, 2 * (q + l) + 2);
            endcase
            if (dur > 160) dur = $urandom_range(1, 160);
            if (dur == 0) dur = 1;
          end
          left[b] = dur;
        end
        left[b]--;
        w.pin_level = level[b];
      end
      send_tick(w);
      tries++;
      if (m[w.button_index]) counted++;
    end
  endtask

  initial begin : receiver
    int unsigned stall_left, hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        tracker.check_event(out_word);
        stall_left = no_idle ? 0 : $urandom_range(0, 16);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned dead_cycles;
    dead_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) dead_cycles = 0;
      else dead_cycles++;
      if (dead_cycles >= StallLimit) begin
        $display("tb_button_click_longclick_detector failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_PUSH_QUALIFY;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: short press gives a click, a too-short hold does not
    send_run(0, 1'b0, 4);
    send_run(0, 1'b1, 1);
    send_run(7, 1'b0, 3);
    send_run(7, 1'b1, 1);
    send_run(3, 1'b1, 1);

    // disabled button, long click then release after it, minimal click
    apply_settings(16'd1, 16'd1, 16'd3, 8'h7F);
    send_run(7, 1'b0, 2);
    send_run(1, 1'b0, 4);
    send_run(1, 1'b1, 1);
    send_run(4, 1'b0, 1);
    send_run(4, 1'b1, 1);

    // zero qualify count: idle line counts as held and released in one tick
    apply_settings(16'd0, 16'd1, 16'd2, 8'hFF);
    send_run(5, 1'b1, 2);
    send_run(5, 1'b0, 1);
    send_run(5, 1'b1, 1);

    // press held well below huge thresholds: no event on release
    apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 8'hFF);
    no_idle = 1'b1;
    send_run(2, 1'b0, 40);
    send_run(2, 1'b1, 2);

    run_phase(16'd3, 16'd2, 16'd100, 8'hFF, 250, 1'b0);
    run_phase(16'd0, 16'd0, 16'd0, 8'hFF, 200, 1'b0);
    run_phase(16'd1, 16'd1, 16'd5, 8'hA5, 200, 1'b0);
    run_phase(16'd2, 16'd3, 16'd8, 8'($urandom_range(1, 255)), 250, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 20, 1'b0);
    run_phase(16'd4, 16'd2, 16'd12, 8'hFF, 250, 1'b1);
    run_phase(16'd1, 16'hFFFF, 16'd6, 8'hFF, 80, 1'b0);
    run_phase(16'd0, 16'd1, 16'd3, 8'hFF, 250, 1'b0);
    run_phase(16'd1, 16'd0, 16'd2, 8'h5A, 200, 1'b0);

    settle();
    if (tracker.faults == 0 && tracker.outstanding() == 0) begin
      $display("tb_button_click_longclick_detector passed");
    end else begin
      $display("tb_button_click_longclick_detector failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bcld_pkg.sv
rtl/bcld_step.sv
rtl/button_click_longclick_detector.sv
bench/tb_button_click_longclick_detector.sv
